// File: hdl/mstg_pkg.sv
// ----------------------------------------------------------------------------
// mstg_pkg
// Shared widths, register codes and pipeline types for the master/stack
// tile geometry block.
// ----------------------------------------------------------------------------
package mstg_pkg;

  localparam int CNT_W             = 7;
  localparam int IDX_W             = 6;
  localparam int COORD_W           = 16;
  localparam int DIM_W             = 14;
  localparam int GAP_W             = 10;
  localparam int RATIO_W           = 16;
  localparam int OUT_W             = 17;
  localparam int MAG_W             = OUT_W;
  localparam int PROD_W            = OUT_W + RATIO_W + 1;
  localparam int CFG_W             = 16;
  localparam int CFG_IDX_W         = 3;
  localparam int DEFAULT_MAX_TILES = 64;

  // register reset values
  localparam logic [COORD_W-1:0] RST_AREA_X       = '0;
  localparam logic [COORD_W-1:0] RST_AREA_Y       = '0;
  localparam logic [DIM_W-1:0]   RST_AREA_WIDTH   = DIM_W'(1920);
  localparam logic [DIM_W-1:0]   RST_AREA_HEIGHT  = DIM_W'(1080);
  localparam logic [GAP_W-1:0]   RST_GAP_SIZE     = '0;
  localparam logic [RATIO_W-1:0] RST_MASTER_RATIO = RATIO_W'(32768);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AREA_X       = 3'd0,
    REG_AREA_Y       = 3'd1,
    REG_AREA_WIDTH   = 3'd2,
    REG_AREA_HEIGHT  = 3'd3,
    REG_GAP_SIZE     = 3'd4,
    REG_MASTER_RATIO = 3'd5
  } cfg_reg_t;

  // usable area after the outer gap, plus raw gap and ratio
  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] w;
    logic signed [OUT_W-1:0] h;
    logic [GAP_W-1:0]        g;
    logic [RATIO_W-1:0]      ratio;
  } geom_t;

  // per-item data riding alongside the divider
  typedef struct packed {
    logic                     ok;
    logic                     single;
    logic                     last;
    logic [IDX_W-1:0]         idx;
    logic                     neg;
    logic signed [PROD_W-1:0] prod;
  } side_t;

endpackage

// File: hdl/mstg_prep.sv
// ----------------------------------------------------------------------------
// mstg_prep
// First stage: count saturation, index check, master width product and
// stack height dividend split into sign and magnitude.
// ----------------------------------------------------------------------------
module mstg_prep #(
  parameter int MAX_TILES = mstg_pkg::DEFAULT_MAX_TILES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [mstg_pkg::CNT_W-1:0]  tile_count,
  input  logic [mstg_pkg::IDX_W-1:0]  tile_index,
  input  mstg_pkg::geom_t             geom,
  output logic                        valid_r,
  output mstg_pkg::side_t             side_r,
  output logic [mstg_pkg::MAG_W-1:0]  mag_r,
  output logic [mstg_pkg::CNT_W-1:0]  den_r
);
  import mstg_pkg::*;

  logic [CNT_W-1:0]       n_sat;
  logic [CNT_W-1:0]       stack;
  logic [CNT_W-1:0]       stk_m1;
  logic [OUT_W-1:0]       gap_prod;
  logic signed [OUT_W:0]  num;
  logic [OUT_W:0]         num_abs;
  side_t                  side_nxt;

  always_comb begin
    if (int'(tile_count) > MAX_TILES) begin
      n_sat = CNT_W'(MAX_TILES);
    end else begin
      n_sat = tile_count;
    end
    stack    = n_sat - CNT_W'(1);
    stk_m1   = stack - CNT_W'(1);
    gap_prod = OUT_W'(stk_m1) * OUT_W'(geom.g);
    // dividend: height less the gaps between stack tiles
    num      = $signed({geom.h[OUT_W-1], geom.h}) - $signed({1'b0, gap_prod});
    num_abs  = num[OUT_W] ? -num : num;

    side_nxt.ok     = (n_sat != '0) && ({1'b0, tile_index} < n_sat);
    side_nxt.single = (n_sat == CNT_W'(1));
    side_nxt.last   = ({1'b0, tile_index} == stack);
    side_nxt.idx    = tile_index;
    side_nxt.neg    = num[OUT_W];
    side_nxt.prod   = geom.w * $signed({1'b0, geom.ratio});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_nxt;
      mag_r  <= num_abs[MAG_W-1:0];
      den_r  <= stack;
    end
  end

endmodule

// File: hdl/mstg_div.sv
// ----------------------------------------------------------------------------
// mstg_div
// Pipelined restoring divider, four quotient bits per stage (fewer in the
// last), with a sideband word carried along.
// ----------------------------------------------------------------------------
module mstg_div #(
  parameter int NUM_W  = mstg_pkg::MAG_W,
  parameter int DEN_W  = mstg_pkg::CNT_W,
  parameter int SIDE_W = $bits(mstg_pkg::side_t)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [NUM_W-1:0]  quot,
  output logic [SIDE_W-1:0] side_out
);
  import mstg_pkg::*;

  localparam int STEPS = 4;
  localparam int NSTG  = (NUM_W + STEPS - 1) / STEPS;

  logic [NSTG-1:0]   v_r;
  logic [NUM_W-1:0]  acc_r  [NSTG];
  logic [DEN_W-1:0]  rem_r  [NSTG];
  logic [DEN_W-1:0]  den_r  [NSTG];
  logic [SIDE_W-1:0] side_r [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    logic              v_i;
    logic [NUM_W-1:0]  acc_i;
    logic [DEN_W-1:0]  rem_i;
    logic [DEN_W-1:0]  den_i;
    logic [SIDE_W-1:0] side_i;
    logic [NUM_W-1:0]  acc_nxt;
    logic [DEN_W-1:0]  rem_nxt;

    if (s == 0) begin : g_first
      assign v_i    = in_valid;
      assign acc_i  = num;
      assign rem_i  = '0;
      assign den_i  = den;
      assign side_i = side_in;
    end else begin : g_next
      assign v_i    = v_r[s-1];
      assign acc_i  = acc_r[s-1];
      assign rem_i  = rem_r[s-1];
      assign den_i  = den_r[s-1];
      assign side_i = side_r[s-1];
    end

    // dividend bits shift out the top, quotient bits shift in the bottom
    always_comb begin
      logic [DEN_W:0] t;
      logic           ge;
      t       = '0;
      ge      = 1'b0;
      acc_nxt = acc_i;
      rem_nxt = rem_i;
      for (int k = 0; k < STEPS; k++) begin
        if (s * STEPS + k < NUM_W) begin
          t       = {rem_nxt, acc_nxt[NUM_W-1]};
          ge      = (t >= {1'b0, den_i});
          rem_nxt = ge ? DEN_W'(t - {1'b0, den_i}) : t[DEN_W-1:0];
          acc_nxt = {acc_nxt[NUM_W-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[s]  <= acc_nxt;
        rem_r[s]  <= rem_nxt;
        den_r[s]  <= den_i;
        side_r[s] <= side_i;
      end
    end
  end

  assign out_valid = v_r[NSTG-1];
  assign quot      = acc_r[NSTG-1];
  assign side_out  = side_r[NSTG-1];

endmodule

// File: hdl/mstg_place.sv
// ----------------------------------------------------------------------------
// mstg_place
// Back end: master width truncation, stack offset product and the final
// tile selection into the output register.
// ----------------------------------------------------------------------------
module mstg_place (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [mstg_pkg::MAG_W-1:0]        quot,
  input  mstg_pkg::side_t                   side,
  input  mstg_pkg::geom_t                   geom,
  output logic                              out_valid,
  output logic signed [mstg_pkg::OUT_W-1:0] out_tile_x,
  output logic signed [mstg_pkg::OUT_W-1:0] out_tile_y,
  output logic signed [mstg_pkg::OUT_W-1:0] out_tile_width,
  output logic signed [mstg_pkg::OUT_W-1:0] out_tile_height,
  output logic                              out_tile_valid
);
  import mstg_pkg::*;

  // stage a
  logic              pneg;
  logic [PROD_W-1:0] pabs;
  logic [OUT_W-1:0]  trunc_mag;
  logic [OUT_W-1:0]  trunc_s;
  logic [OUT_W-1:0]  mw_nxt;
  logic [OUT_W-1:0]  sh_nxt;
  logic [OUT_W-1:0]  sw_nxt;
  logic [OUT_W-1:0]  shg_nxt;
  logic              a_valid_r;
  side_t             a_side_r;
  logic [OUT_W-1:0]  a_mw_r;
  logic [OUT_W-1:0]  a_sw_r;
  logic [OUT_W-1:0]  a_sh_r;
  logic [OUT_W-1:0]  a_shg_r;

  // stage b
  logic [IDX_W-1:0]       idx_m1;
  logic [IDX_W+OUT_W-1:0] offs_full;
  logic                   b_valid_r;
  side_t                  b_side_r;
  logic [OUT_W-1:0]       b_mw_r;
  logic [OUT_W-1:0]       b_sw_r;
  logic [OUT_W-1:0]       b_sh_r;
  logic [OUT_W-1:0]       b_offs_r;

  // output stage
  logic [OUT_W-1:0] x_nxt;
  logic [OUT_W-1:0] y_nxt;
  logic [OUT_W-1:0] w_nxt;
  logic [OUT_W-1:0] h_nxt;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_x_r;
  logic [OUT_W-1:0] out_y_r;
  logic [OUT_W-1:0] out_w_r;
  logic [OUT_W-1:0] out_h_r;
  logic             out_ok_r;

  always_comb begin
    // scale toward zero, then take off half the gap
    pneg      = side.prod[PROD_W-1];
    pabs      = pneg ? PROD_W'(-side.prod) : PROD_W'(side.prod);
    trunc_mag = pabs[PROD_W-2:RATIO_W];
    trunc_s   = pneg ? -trunc_mag : trunc_mag;
    mw_nxt    = trunc_s - OUT_W'(geom.g[GAP_W-1:1]);
    sh_nxt    = side.neg ? -quot : quot;
    sw_nxt    = OUT_W'(geom.w) - mw_nxt - OUT_W'(geom.g);
    shg_nxt   = sh_nxt + OUT_W'(geom.g);
  end

  always_comb begin
    idx_m1    = a_side_r.idx - IDX_W'(1);
    offs_full = idx_m1 * a_shg_r;
  end

  always_comb begin
    x_nxt = '0;
    y_nxt = '0;
    w_nxt = '0;
    h_nxt = '0;
    if (b_side_r.ok) begin
      if (b_side_r.single) begin
        x_nxt = geom.x;
        y_nxt = geom.y;
        w_nxt = geom.w;
        h_nxt = geom.h;
      end else if (b_side_r.idx == '0) begin
        x_nxt = geom.x;
        y_nxt = geom.y;
        w_nxt = b_mw_r;
        h_nxt = geom.h;
      end else begin
        x_nxt = OUT_W'(geom.x) + b_mw_r + OUT_W'(geom.g);
        y_nxt = OUT_W'(geom.y) + b_offs_r;
        w_nxt = b_sw_r;
        // bottom tile takes what the truncation left over
        h_nxt = b_side_r.last ? OUT_W'(geom.h) - b_offs_r : b_sh_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r   <= in_valid;
      b_valid_r   <= a_valid_r;
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side_r <= side;
      a_mw_r   <= mw_nxt;
      a_sw_r   <= sw_nxt;
      a_sh_r   <= sh_nxt;
      a_shg_r  <= shg_nxt;
      b_side_r <= a_side_r;
      b_mw_r   <= a_mw_r;
      b_sw_r   <= a_sw_r;
      b_sh_r   <= a_sh_r;
      b_offs_r <= offs_full[OUT_W-1:0];
      out_x_r  <= x_nxt;
      out_y_r  <= y_nxt;
      out_w_r  <= w_nxt;
      out_h_r  <= h_nxt;
      out_ok_r <= b_side_r.ok;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tile_x      = $signed(out_x_r);
  assign out_tile_y      = $signed(out_y_r);
  assign out_tile_width  = $signed(out_w_r);
  assign out_tile_height = $signed(out_h_r);
  assign out_tile_valid  = out_ok_r;

endmodule

// File: hdl/master_stack_tile_geometry.sv
// pipeline: one prep stage, five divider stages (four quotient bits each,
//   one in the last) and three placement stages
// throughput: one tile request per cycle; a stalled result freezes every stage
// reset: synchronous active-low rst_n clears all stage valid bits and loads
//   the configuration registers with their default values
// ----------------------------------------------------------------------------
// master_stack_tile_geometry
// Rectangle of one window in a master/stack tiled layout, computed in a
// nine-stage pipeline from the configured area, gap and master ratio.
// ----------------------------------------------------------------------------
module master_stack_tile_geometry #(
  parameter int MAX_TILES = mstg_pkg::DEFAULT_MAX_TILES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration writes, only while idle
  input  logic                              cfg_we,
  input  logic [mstg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mstg_pkg::CFG_W-1:0]        cfg_wdata,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mstg_pkg::CNT_W-1:0]        in_tile_count,
  input  logic [mstg_pkg::IDX_W-1:0]        in_tile_index,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [mstg_pkg::OUT_W-1:0] out_tile_x,
  output logic signed [mstg_pkg::OUT_W-1:0] out_tile_y,
  output logic signed [mstg_pkg::OUT_W-1:0] out_tile_width,
  output logic signed [mstg_pkg::OUT_W-1:0] out_tile_height,
  output logic                              out_tile_valid
);
  import mstg_pkg::*;

  // configuration registers
  logic [COORD_W-1:0] area_x_r;
  logic [COORD_W-1:0] area_y_r;
  logic [DIM_W-1:0]   area_width_r;
  logic [DIM_W-1:0]   area_height_r;
  logic [GAP_W-1:0]   gap_size_r;
  logic [RATIO_W-1:0] master_ratio_r;

  geom_t            geom;
  logic             en;

  // stage 1 to divider
  logic             p_valid;
  side_t            p_side;
  logic [MAG_W-1:0] p_mag;
  logic [CNT_W-1:0] p_den;

  // divider to placement
  logic             d_valid;
  side_t            d_side;
  logic [MAG_W-1:0] d_quot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_x_r       <= RST_AREA_X;
      area_y_r       <= RST_AREA_Y;
      area_width_r   <= RST_AREA_WIDTH;
      area_height_r  <= RST_AREA_HEIGHT;
      gap_size_r     <= RST_GAP_SIZE;
      master_ratio_r <= RST_MASTER_RATIO;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_AREA_X:       area_x_r       <= cfg_wdata;
        REG_AREA_Y:       area_y_r       <= cfg_wdata;
        REG_AREA_WIDTH:   area_width_r   <= cfg_wdata[DIM_W-1:0];
        REG_AREA_HEIGHT:  area_height_r  <= cfg_wdata[DIM_W-1:0];
        REG_GAP_SIZE:     gap_size_r     <= cfg_wdata[GAP_W-1:0];
        REG_MASTER_RATIO: master_ratio_r <= cfg_wdata[RATIO_W-1:0];
        default: ; // unused indexes drop the write
      endcase
    end
  end

  // usable area: shrink the configured area by the gap on every side;
  // the user must make config changes only while idle, unchecked by the block; every stage reads it directly
  always_comb begin
    geom.x     = $signed(OUT_W'($signed(area_x_r))) + $signed(OUT_W'(gap_size_r));
    geom.y     = $signed(OUT_W'($signed(area_y_r))) + $signed(OUT_W'(gap_size_r));
    geom.w     = $signed(OUT_W'(area_width_r) - OUT_W'({gap_size_r, 1'b0}));
    geom.h     = $signed(OUT_W'(area_height_r) - OUT_W'({gap_size_r, 1'b0}));
    geom.g     = gap_size_r;
    geom.ratio = master_ratio_r;
  end

  // whole pipe advances unless a finished result is held by the sink
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  mstg_prep #(
    .MAX_TILES (MAX_TILES)
  ) u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_valid),
    .tile_count (in_tile_count),
    .tile_index (in_tile_index),
    .geom       (geom),
    .valid_r    (p_valid),
    .side_r     (p_side),
    .mag_r      (p_mag),
    .den_r      (p_den)
  );

  // stack height magnitude divided by the number of stack tiles
  mstg_div #(
    .NUM_W  (MAG_W),
    .DEN_W  (CNT_W),
    .SIDE_W ($bits(side_t))
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p_valid),
    .num       (p_mag),
    .den       (p_den),
    .side_in   (p_side),
    .out_valid (d_valid),
    .quot      (d_quot),
    .side_out  (d_side)
  );

  mstg_place u_place (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (en),
    .in_valid        (d_valid),
    .quot            (d_quot),
    .side            (d_side),
    .geom            (geom),
    .out_valid       (out_valid),
    .out_tile_x      (out_tile_x),
    .out_tile_y      (out_tile_y),
    .out_tile_width  (out_tile_width),
    .out_tile_height (out_tile_height),
    .out_tile_valid  (out_tile_valid)
  );

  // an out-of-range tile carries an all-zero rectangle
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_tile_valid) |->
      (out_tile_x == '0) && (out_tile_y == '0) &&
      (out_tile_width == '0) && (out_tile_height == '0))
    else $error("invalid tile with nonzero rectangle");

  // input side only backs up behind a held result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with no held result");

  // while frozen the result register keeps its rectangle
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_stall) && $past(rst_n) |->
      $stable(out_tile_x) && $stable(out_tile_height) && out_valid)
    else $error("frozen pipeline changed its result");

endmodule

// File: test/tb_master_stack_tile_geometry.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_master_stack_tile_geometry
// Self-checking bench for the master/stack tile geometry block. A local
// geometry predictor runs beside the block and produces the expected
// rectangle for every request transfer. Each result is checked field by
// field against the oldest pending rectangle. The run covers directed
// corners, then random layouts under four idling phases.
// ----------------------------------------------------------------------------
module tb_master_stack_tile_geometry;
  import mstg_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int TILE_LIMIT  = DEFAULT_MAX_TILES;
  localparam int PRINT_LIMIT = 40;
  localparam int PIPE_FLUSH  = 12;  // a little past the depth of the nine-stage pipeline

  // indexes past the register list, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  // expected rectangle of one tile
  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic [OUT_W-1:0] w;
    logic [OUT_W-1:0] h;
    logic             valid;
  } tile_rect_t;

  // dut ports, every input known from time zero
  logic                     clk           = 1'b0;
  logic                     rst_n         = 1'b0;
  logic                     cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index     = '0;
  logic [CFG_W-1:0]         cfg_wdata     = '0;
  logic                     in_valid      = 1'b0;
  logic                     in_stall;
  logic [CNT_W-1:0]         in_tile_count = '0;
  logic [IDX_W-1:0]         in_tile_index = '0;
  logic                     out_valid;
  logic                     out_stall     = 1'b0;
  logic signed [OUT_W-1:0]  out_tile_x;
  logic signed [OUT_W-1:0]  out_tile_y;
  logic signed [OUT_W-1:0]  out_tile_width;
  logic signed [OUT_W-1:0]  out_tile_height;
  logic                     out_tile_valid;

  // local copy of the layout registers, kept in step with every write
  logic signed [COORD_W-1:0] area_x_q   = RST_AREA_X;
  logic signed [COORD_W-1:0] area_y_q   = RST_AREA_Y;
  logic [DIM_W-1:0]          area_w_q   = RST_AREA_WIDTH;
  logic [DIM_W-1:0]          area_h_q   = RST_AREA_HEIGHT;
  logic [GAP_W-1:0]          gap_q      = RST_GAP_SIZE;
  logic [RATIO_W-1:0]        ratio_q    = RST_MASTER_RATIO;

  // rectangles predicted but not yet seen on the result channel
  tile_rect_t pending_tiles[$];

  int mismatch_count = 0;
  int sender_idle_pct = 0;  // chance per cycle that the request side holds off
  int recv_stall_pct  = 0;  // chance per cycle that the result side stalls

  master_stack_tile_geometry dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_tile_count   (in_tile_count),
    .in_tile_index   (in_tile_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_tile_x      (out_tile_x),
    .out_tile_y      (out_tile_y),
    .out_tile_width  (out_tile_width),
    .out_tile_height (out_tile_height),
    .out_tile_valid  (out_tile_valid)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // result side back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // geometry predictor
  // ---------------------------------------------------------------------------
  function automatic tile_rect_t predict_tile(input logic [CNT_W-1:0] cnt,
                                              input logic [IDX_W-1:0] idx);
    longint     n, i, g, x, y, w, h;
    longint     mw, sw, stack, sh, sy;
    longint     rx, ry, rw, rh;
    tile_rect_t r;
    n  = longint'(cnt);
    i  = longint'(idx);
    g  = longint'(gap_q);
    // usable area after the outer gap
    x  = longint'(area_x_q) + g;
    y  = longint'(area_y_q) + g;
    w  = longint'(area_w_q) - 2 * g;
    h  = longint'(area_h_q) - 2 * g;
    rx = 0;
    ry = 0;
    rw = 0;
    rh = 0;
    r  = '0;
    if (n > TILE_LIMIT) n = TILE_LIMIT;
    if (n > 0 && i < n) begin
      r.valid = 1'b1;
      if (n == 1) begin
        rx = x;
        ry = y;
        rw = w;
        rh = h;
      end else begin
        // signed division truncates toward zero, as the q16 scaling wants
        mw    = (w * longint'(ratio_q)) / 65536 - g / 2;
        sw    = w - mw - g;
        stack = n - 1;
        if (i == 0) begin
          rx = x;
          ry = y;
          rw = mw;
          rh = h;
        end else begin
          sh = (h - (stack - 1) * g) / stack;
          sy = y + (i - 1) * (sh + g);
          // bottom tile takes whatever the even split left over
          if (i == stack) sh = y + h - sy;
          rx = x + mw + g;
          ry = sy;
          rw = sw;
          rh = sh;
        end
      end
    end
    r.x = rx[OUT_W-1:0];
    r.y = ry[OUT_W-1:0];
    r.w = rw[OUT_W-1:0];
    r.h = rh[OUT_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // mismatch reporting and result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [OUT_W-1:0] got,
                             input logic [OUT_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // every result transfer is matched against the oldest predicted rectangle
  always @(posedge clk) begin : result_check
    tile_rect_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_tiles.size() == 0) begin
        report_mismatch("result transfer with no request pending");
      end else begin
        want = pending_tiles.pop_front();
        check_field("tile_x", out_tile_x, want.x);
        check_field("tile_y", out_tile_y, want.y);
        check_field("tile_width", out_tile_width, want.w);
        check_field("tile_height", out_tile_height, want.h);
        check_field("tile_valid", OUT_W'(out_tile_valid), OUT_W'(want.valid));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request side and register writes
  // ---------------------------------------------------------------------------
  // one request transfer; valid is left high so back-to-back requests
  // never lower and raise it in the same step
  task automatic send_tile(input logic [CNT_W-1:0] cnt, input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_tile_count <= cnt;
    in_tile_index <= idx;
    do @(posedge clk); while (in_stall);
    // transfer taken at this edge, predict it with the current layout
    pending_tiles.push_back(predict_tile(cnt, idx));
  endtask

  // stop requesting and wait for every pending rectangle to come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_tiles.size() != 0) @(posedge clk);
  endtask

  // one register write; write enable stays high for chained writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_AREA_X:       area_x_q = data[COORD_W-1:0];
      REG_AREA_Y:       area_y_q = data[COORD_W-1:0];
      REG_AREA_WIDTH:   area_w_q = data[DIM_W-1:0];
      REG_AREA_HEIGHT:  area_h_q = data[DIM_W-1:0];
      REG_GAP_SIZE:     gap_q    = data[GAP_W-1:0];
      REG_MASTER_RATIO: ratio_q  = data[RATIO_W-1:0];
      default: ;  // past the register list, dropped
    endcase
  endtask

  // full layout setup, only called with the pipeline empty
  task automatic program_geometry(input logic [CFG_W-1:0] x, input logic [CFG_W-1:0] y,
                                  input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                  input logic [CFG_W-1:0] g, input logic [CFG_W-1:0] r);
    write_reg(REG_AREA_X, x);
    write_reg(REG_AREA_Y, y);
    write_reg(REG_AREA_WIDTH, w);
    write_reg(REG_AREA_HEIGHT, h);
    write_reg(REG_GAP_SIZE, g);
    write_reg(REG_MASTER_RATIO, r);
    cfg_we <= 1'b0;
  endtask

  // low end, high end or anything, unused upper bits stay random
  function automatic logic [CFG_W-1:0] pick_reg_value(input logic [CFG_W-1:0] lo,
                                                      input logic [CFG_W-1:0] hi);
    case ($urandom_range(5))
      0:       return lo;
      1:       return hi;
      default: return CFG_W'($urandom);
    endcase
  endfunction

  task automatic program_random_geometry();
    // occasionally poke the unused indexes as well
    if ($urandom_range(3) == 0) write_reg(REG_SPARE_A, CFG_W'($urandom));
    if ($urandom_range(3) == 0) write_reg(REG_SPARE_B, CFG_W'($urandom));
    program_geometry(pick_reg_value(16'h8000, 16'h7FFF),
                     pick_reg_value(16'h8000, 16'h7FFF),
                     pick_reg_value(16'h0000, 16'h3FFF),
                     pick_reg_value(16'h0000, 16'h3FFF),
                     pick_reg_value(16'h0000, 16'h03FF),
                     pick_reg_value(16'h0000, 16'hFFFF));
  endtask

  // mostly real layouts, with empty, saturating and out-of-range requests mixed in
  task automatic send_random_tile();
    logic [CNT_W-1:0] cnt;
    logic [IDX_W-1:0] idx;
    int               live;
    case ($urandom_range(19))
      0:       cnt = '0;
      1, 2:    cnt = CNT_W'($urandom_range(127, TILE_LIMIT + 1));
      3, 4, 5: cnt = CNT_W'($urandom_range(4, 1));
      default: cnt = CNT_W'($urandom_range(TILE_LIMIT, 1));
    endcase
    live = (cnt > TILE_LIMIT) ? TILE_LIMIT : int'(cnt);
    if (live > 0 && $urandom_range(9) < 8) begin
      // favor the master and the bottom stack tile
      case ($urandom_range(5))
        0:       idx = '0;
        1:       idx = IDX_W'(live - 1);
        default: idx = IDX_W'($urandom_range(live - 1));
      endcase
    end else begin
      idx = IDX_W'($urandom);
    end
    send_tile(cnt, idx);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // layout straight out of reset: single tile, master, stack, empty and
  // out-of-range requests, count saturation
  task automatic test_reset_defaults();
    send_tile(7'd1, 6'd0);
    send_tile(7'd2, 6'd0);
    send_tile(7'd2, 6'd1);
    send_tile(7'd3, 6'd1);
    send_tile(7'd3, 6'd2);    // bottom tile absorbs the remainder
    send_tile(7'd0, 6'd0);    // empty layout
    send_tile(7'd5, 6'd5);    // index equal to count
    send_tile(7'd1, 6'd63);
    send_tile(7'd64, 6'd63);
    send_tile(7'd127, 6'd63); // count saturates to the tile limit
    send_tile(7'd65, 6'd0);
    send_tile(7'd100, 6'd10);
    drain_results();
  endtask

  // register extremes: far corners, biggest gap, full and zero ratio,
  // zero-sized area so widths go negative, near-zero ratio
  task automatic test_extreme_geometry();
    program_geometry(16'h8000, 16'h7FFF, 16'h3FFF, 16'h3FFF, 16'h03FF, 16'hFFFF);
    send_tile(7'd1, 6'd0);
    send_tile(7'd2, 6'd0);
    send_tile(7'd2, 6'd1);
    send_tile(7'd64, 6'd63);
    send_tile(7'd64, 6'd1);
    send_tile(7'd7, 6'd6);
    drain_results();
    program_geometry(16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h03FF, 16'h0000);
    send_tile(7'd1, 6'd0);
    send_tile(7'd2, 6'd0);
    send_tile(7'd2, 6'd1);
    send_tile(7'd64, 6'd63);
    drain_results();
    program_geometry(16'h0000, 16'h0000, 16'd100, 16'd100, 16'd3, 16'h0001);
    send_tile(7'd3, 6'd0);
    send_tile(7'd3, 6'd2);
    drain_results();
  endtask

  // writes past the register list must leave the layout alone
  task automatic test_unused_registers();
    write_reg(REG_SPARE_A, 16'hFFFF);
    write_reg(REG_SPARE_B, 16'h5A5A);
    cfg_we <= 1'b0;
    send_tile(7'd4, 6'd0);
    send_tile(7'd4, 6'd3);
    drain_results();
  endtask

  // random layouts and requests under one idling phase
  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    for (int k = 0; k < 3; k++) begin
      program_random_geometry();
      repeat (113) send_random_tile();
      drain_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_extreme_geometry();
    test_unused_registers();

    // no idling, sender idle, receiver stalling, then both
    test_random_traffic(0, 0);
    test_random_traffic(85, 0);
    test_random_traffic(0, 85);
    test_random_traffic(28, 28);

    // let anything stray fall out of the pipeline
    repeat (PIPE_FLUSH) @(posedge clk);
    if (pending_tiles.size() != 0)
      report_mismatch($sformatf("%0d rectangles never returned", pending_tiles.size()));

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
